/* rtl/core/acmac_pkg.sv */
`timescale 1ns / 1ps
package acmac_pkg;

    localparam int TAG_BYTES_DEFAULT = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] DBL_POLY = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [1:0] JOB_CHAIN  = 2'd0;
    localparam logic [1:0] JOB_LAST_FULL = 2'd1;
    localparam logic [1:0] JOB_LAST_PAD  = 2'd2;

    typedef struct packed {
        logic [1:0]   kind;
        logic [127:0] block;
        logic [63:0]  expected_tag;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? DBL_POLY : 8'h00)};
    endfunction

    // Byte k of a block lies in bits 127-8k down to 120-8k.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
        logic [7:0] b [0:15];
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int k = 0; k < 16; k++)
        begin
            b[k] = sbox(s[127-8*k -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                t[c*4+k] = b[((c+k)%4)*4+k];
            end
        end
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            r[127-8*k -: 8] = t[k];
        end
        return r ^ rk;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] w;
        logic [127:0] n;
        w = {sbox(rk[23:16]) ^ rcon, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
        n[127:96] = rk[127:96] ^ w;
        n[95:64]  = rk[95:64] ^ n[127:96];
        n[63:32]  = rk[63:32] ^ n[95:64];
        n[31:0]   = rk[31:0] ^ n[63:32];
        return n;
    endfunction

endpackage

/* rtl/core/acmac_if.sv */
`timescale 1ns / 1ps
interface acmac_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic [63:0] expected_tag;
    modport source (output valid, data_byte, has_byte, end_of_message, expected_tag,
                    input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, expected_tag,
                  output ready);
endinterface

interface acmac_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] mac_high;
    logic [63:0] mac_low;
    logic        status;
    modport source (output valid, mac_high, mac_low, status, input ready);
    modport sink (input valid, mac_high, mac_low, status, output ready);
endinterface

/* rtl/core/acmac_front.sv */
`timescale 1ns / 1ps
module acmac_front (
    input  logic         clk,
    input  logic         rst_n,
    acmac_in_if.sink     in_w,
    output logic         job_valid,
    output acmac_pkg::job_t job,
    input  logic         job_ready
);
    import acmac_pkg::*;

    logic [127:0] buf_reg;
    logic [4:0]   fill_reg;
    logic         nonempty_reg;
    logic [127:0] nb;
    logic [4:0]   nf;
    logic         ne;
    logic         need_chain;
    logic         chain_first;
    logic [3:0]   pos;
    logic [127:0] pad;

    // A byte that arrives at a full buffer and also ends the message takes two jobs:
    // the chain job goes first and the word is held until the final job can follow.
    logic split_reg;
    logic stall;

    // A full buffer is sent as a chain job only when a further byte arrives.
    assign need_chain = in_w.has_byte && (fill_reg == 5'd16);
    assign chain_first = need_chain && !split_reg;
    assign stall = chain_first && in_w.end_of_message;
    assign in_w.ready = job_ready && !stall;

    always_comb
    begin
        nb = buf_reg;
        nf = need_chain ? 5'd0 : fill_reg;
        ne = nonempty_reg;
        if (in_w.has_byte)
        begin
            pos = nf[3:0];
            nb[127 - 8*pos -: 8] = in_w.data_byte;
            nf = nf + 5'd1;
            ne = 1'b1;
        end
        else
        begin
            pos = 4'd0;
        end
        pad = nb;
        for (int k = 0; k < 16; k++)
        begin
            if (k[4:0] > nf)
            begin
                pad[127-8*k -: 8] = 8'h00;
            end
            else if (k[4:0] == nf)
            begin
                pad[127-8*k -: 8] = PAD_BYTE;
            end
        end
    end

    always_comb
    begin
        job.expected_tag = in_w.expected_tag;
        job_valid = 1'b0;
        job.kind = JOB_CHAIN;
        job.block = buf_reg;
        if (in_w.valid && chain_first)
        begin
            job_valid = 1'b1;
        end
        else if (in_w.valid && in_w.end_of_message)
        begin
            job_valid = 1'b1;
            if (ne && nf == 5'd16)
            begin
                job.kind = JOB_LAST_FULL;
                job.block = nb;
            end
            else
            begin
                job.kind = JOB_LAST_PAD;
                job.block = pad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 5'd0;
            nonempty_reg <= 1'b0;
            split_reg <= 1'b0;
        end
        else
        begin
            if (stall && job_ready)
            begin
                split_reg <= 1'b1;
            end
            else if (in_w.valid && in_w.ready)
            begin
                split_reg <= 1'b0;
            end
            if (in_w.valid && in_w.ready)
            begin
                if (in_w.end_of_message)
                begin
                    fill_reg <= 5'd0;
                    nonempty_reg <= 1'b0;
                end
                else
                begin
                    fill_reg <= nf;
                    nonempty_reg <= ne;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_w.valid && in_w.ready)
        begin
            buf_reg <= nb;
        end
    end
endmodule

/* rtl/core/acmac_queue.sv */
`timescale 1ns / 1ps
module acmac_queue #(
    parameter int DEPTH = acmac_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  acmac_pkg::job_t   wr_job,
    output logic              wr_ready,
    output logic              rd_valid,
    output acmac_pkg::job_t   rd_job,
    input  logic              rd_ready
);
    import acmac_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t           mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           do_wr, do_rd;

    assign wr_ready = (cnt_reg != DEPTH[AW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign rd_job = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{AW{1'b0}}, do_wr} - {{AW{1'b0}}, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_job;
        end
    end
endmodule

/* rtl/core/acmac_back.sv */
`timescale 1ns / 1ps
module acmac_back #(
    parameter int TAG_BYTES = acmac_pkg::TAG_BYTES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [127:0]    key,
    input  logic            key_wr,
    input  logic            job_valid,
    input  acmac_pkg::job_t job,
    output logic            job_ready,
    acmac_out_if.source     out_w
);
    import acmac_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_KEY  = 3'd2;
    localparam logic [2:0] S_HOLD = 3'd3;

    localparam logic [63:0] CMP_MASK = ~64'd0 << (8 * (8 - TAG_BYTES));

    logic [2:0]   state_reg;
    logic [3:0]   round_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] st_reg, rk_reg, chain_reg, k1_reg, k2_reg;
    logic [1:0]   kind_reg;
    logic [63:0]  tag_reg;
    logic         key_pend_reg;
    logic [127:0] rk_n, st_n;
    logic         out_load;

    assign rk_n = key_step(rk_reg, rcon_reg);
    assign st_n = aes_round(st_reg, rk_n, round_reg == 4'd10);
    assign job_ready = (state_reg == S_IDLE) && !key_pend_reg && !key_wr;
    assign out_load = (state_reg == S_HOLD) && (!out_w.valid || out_w.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_KEY;
            round_reg <= 4'd1;
            rcon_reg <= 8'h01;
            rk_reg <= '0;
            st_reg <= '0;
            chain_reg <= '0;
            out_w.valid <= 1'b0;
            key_pend_reg <= 1'b0;
            kind_reg <= JOB_CHAIN;
        end
        else
        begin
            if (out_load)
            begin
                out_w.valid <= 1'b1;
            end
            else if (out_w.valid && out_w.ready)
            begin
                out_w.valid <= 1'b0;
            end
            if (key_wr)
            begin
                key_pend_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (key_pend_reg && !key_wr)
                    begin
                        key_pend_reg <= 1'b0;
                        state_reg <= S_KEY;
                        round_reg <= 4'd1;
                        rcon_reg <= 8'h01;
                        rk_reg <= key;
                        st_reg <= key;
                    end
                    else if (job_valid && job_ready)
                    begin
                        kind_reg <= job.kind;
                        tag_reg <= job.expected_tag;
                        round_reg <= 4'd1;
                        rcon_reg <= 8'h01;
                        rk_reg <= key;
                        st_reg <= job.block ^ chain_reg ^ key ^
                                  ((job.kind == JOB_LAST_FULL) ? k1_reg :
                                   (job.kind == JOB_LAST_PAD) ? k2_reg : 128'd0);
                        state_reg <= S_RUN;
                    end
                end
                S_RUN, S_KEY:
                begin
                    rk_reg <= rk_n;
                    st_reg <= st_n;
                    rcon_reg <= xtime(rcon_reg);
                    round_reg <= round_reg + 4'd1;
                    if (round_reg == 4'd10)
                    begin
                        if (state_reg == S_KEY)
                        begin
                            k1_reg <= dbl(st_n);
                            k2_reg <= dbl(dbl(st_n));
                            state_reg <= S_IDLE;
                        end
                        else if (kind_reg == JOB_CHAIN)
                        begin
                            chain_reg <= st_n;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            chain_reg <= '0;
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD:
                begin
                    if (out_load)
                    begin
                        out_w.mac_high <= st_reg[127:64];
                        out_w.mac_low <= st_reg[63:0];
                        out_w.status <= ((st_reg[127:64] ^ tag_reg) & CMP_MASK) != 64'd0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* rtl/core/aes_cmac_tag_engine_core.sv */
`timescale 1ns / 1ps
// AES-128 CMAC engine taking one message byte per word. Bytes are accepted every cycle,
// unless the queue is full or a word is held, into a 16-byte buffer; each full block goes
// through a four-entry queue to an iterative AES core that does one round per cycle and
// finishes a block well before the next block fills, so one byte per cycle is sustained
// within a long message. A word that ends a message and also brings the byte after a full
// buffer sends two blocks and is held while the first is sent. The final block of a
// message holds the core until its result word is loaded into the output. The word that
// ends a message passes through the queue, the AES rounds and the hold state before its
// result word appears. The subkeys are derived after reset and after each key write; words
// are still taken into the queue meanwhile and wait there.
module aes_cmac_tag_engine_core #(
    parameter int TAG_BYTES = acmac_pkg::TAG_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    acmac_in_if.sink    in_w,
    acmac_out_if.source out_w
);
    import acmac_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic        key_wr;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    job_t        fq_job, qb_job;

    assign pready = 1'b1;
    assign key_wr = psel && penable && pwrite && (paddr == 4'd0 || paddr == 4'd8);
    assign prdata = (paddr == 4'd0) ? key_high_reg : (paddr == 4'd8) ? key_low_reg : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 4'd0)
            begin
                key_high_reg <= pwdata;
            end
            if (paddr == 4'd8)
            begin
                key_low_reg <= pwdata;
            end
        end
    end

    acmac_front u_front (
        .clk(clk), .rst_n(rst_n), .in_w(in_w),
        .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
    );

    acmac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_job(fq_job), .wr_ready(fq_ready),
        .rd_valid(qb_valid), .rd_job(qb_job), .rd_ready(qb_ready)
    );

    acmac_back #(.TAG_BYTES(TAG_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .key({key_high_reg, key_low_reg}), .key_wr(key_wr),
        .job_valid(qb_valid), .job(qb_job), .job_ready(qb_ready),
        .out_w(out_w)
    );
endmodule
